[sv/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int NUM_LEDS     = 16;
  localparam int NUM_PATTERNS = 8;
  localparam int NUM_STEPS    = 16;

  localparam logic [3:0] MODE_TICK      = 4'd0;
  localparam logic [3:0] MODE_ASSIGN    = 4'd1;
  localparam logic [3:0] MODE_ENABLE    = 4'd2;
  localparam logic [3:0] MODE_DISABLE   = 4'd3;
  localparam logic [3:0] MODE_OFFSET    = 4'd4;
  localparam logic [3:0] MODE_STEP_WR   = 4'd5;
  localparam logic [3:0] MODE_HEADER_WR = 4'd6;
  localparam logic [3:0] MODE_FORCE_ON  = 4'd7;
  localparam logic [3:0] MODE_FORCE_OFF = 4'd8;

  localparam logic [0:0] CFG_LED_COUNT = 1'd0;
  localparam logic [0:0] CFG_TICK_MS   = 1'd1;

  localparam logic KIND_PIN    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // one command word as it enters the queue
  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  led_id;
    logic [2:0]  seq_id;
    logic [3:0]  step_index;
    logic        level;
    logic [4:0]  seq_length;
    logic [15:0] seq_period;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic       kind;
    logic [3:0] led_index;
    logic       pin_level;
    logic       status;
    logic       last;
  } res_t;

endpackage

[sv/lps_front.sv]
// ----------------------------------------------------------------------------
// lps_front
// Input stage and command queue: accepts words, drops unknown modes.
// ----------------------------------------------------------------------------
module lps_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lps_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_pop,
  output lps_pkg::cmd_t q_cmd
);
  import lps_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  // drop unknown modes at the door
  assign push     = in_valid && in_ready && (in_cmd.mode <= MODE_FORCE_OFF);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ (q_pop && q_valid);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
  end

endmodule

[sv/lps_back.sv]
// ----------------------------------------------------------------------------
// lps_back
// Executes commands: holds LED and pattern state, walks LEDs on a tick.
// ----------------------------------------------------------------------------
module lps_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_idx,
  input  logic [15:0]   cfg_data,
  input  logic          q_valid,
  output logic          q_pop,
  input  lps_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output lps_pkg::res_t out_res,
  output logic          busy
);
  import lps_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [4:0]  led_count_r;
  logic [15:0] tick_ms_r;

  logic [NUM_LEDS-1:0] en_r, asg_r, st_r;
  logic [2:0]  pat_r  [NUM_LEDS];
  logic [3:0]  pos_r  [NUM_LEDS];
  logic [31:0] ela_r  [NUM_LEDS];
  logic [NUM_STEPS-1:0] bits_r [NUM_PATTERNS];
  logic [4:0]  len_r  [NUM_PATTERNS];
  logic [15:0] thr_r  [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] sval_r;

  logic [1:0]  state_r;
  logic [4:0]  idx_r;
  logic        hold_v_r;
  res_t        hold_r;
  logic        pend_v_r;
  res_t        pend_r;

  // divider for header write
  logic [15:0] dq_r, drem_r;
  logic [4:0]  dcnt_r, dlen_r;
  logic [2:0]  dsid_r;

  logic [4:0]  live;
  logic        wk_done;
  logic [3:0]  wi;
  logic [2:0]  wp;
  logic        wact;
  logic [32:0] esum;
  logic [31:0] esat, enew;
  logic        adv;
  logic [3:0]  pnew;
  logic [16:0] dtrial;
  logic [4:0]  clen;
  logic        outfree;
  logic        walk_emit;

  // any enabled, playing LED at or after index k
  function automatic logic has_more(input logic [4:0] k);
    logic r;
    r = 1'b0;
    for (int j = 0; j < NUM_LEDS; j++)
      if (5'(j) >= k && 5'(j) < live && en_r[j] && asg_r[j] && sval_r[pat_r[j]])
        r = 1'b1;
    return r;
  endfunction

  assign live    = (led_count_r > 5'd16) ? 5'd16 : led_count_r;
  assign busy    = (state_r != ST_IDLE) || pend_v_r || hold_v_r || q_valid;
  assign out_valid = hold_v_r;
  assign out_res   = hold_r;
  assign outfree   = !hold_v_r || out_ready;

  assign wi   = idx_r[3:0];
  assign wp   = pat_r[wi];
  assign wact = asg_r[wi] && sval_r[wp];
  assign esum = {1'b0, ela_r[wi]} + {17'd0, tick_ms_r};
  assign esat = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
  assign adv  = (esat >= {16'd0, thr_r[wp]}) && st_r[wi];
  assign pnew = adv ? (({1'b0, pos_r[wi]} + 5'd1 > len_r[wp] - 5'd1) ? 4'd0 : pos_r[wi] + 4'd1)
                    : pos_r[wi];
  assign enew = adv ? esat - {16'd0, thr_r[wp]} : esat;
  assign wk_done = (idx_r >= live);
  assign dtrial = {drem_r, dq_r[15]} - {12'd0, dlen_r};
  assign clen = (q_cmd.seq_length == 5'd0) ? 5'd1 :
                (q_cmd.seq_length > 5'd16) ? 5'd16 : q_cmd.seq_length;

  // walk loads a new pin word into the pending slot this cycle
  assign walk_emit = (state_r == ST_WALK) && !(pend_v_r && !outfree) && !wk_done &&
                     wact && en_r[wi];

  // pop a queued word only when idle and the pending slot is empty
  assign q_pop = (state_r == ST_IDLE) && q_valid && !pend_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= 5'd0;
      tick_ms_r   <= 16'd0;
      state_r     <= ST_IDLE;
      idx_r       <= 5'd0;
      hold_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      en_r        <= '1;
      asg_r       <= '0;
      st_r        <= '0;
      sval_r      <= {{(NUM_PATTERNS-2){1'b0}}, 2'b11};
      for (int i = 0; i < NUM_LEDS; i++) begin
        pat_r[i] <= 3'd0;
        pos_r[i] <= 4'd0;
        ela_r[i] <= 32'd0;
      end
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        bits_r[p] <= (p == 1) ? {{(NUM_STEPS-1){1'b0}}, 1'b1} : '0;
        len_r[p]  <= 5'd1;
        thr_r[p]  <= 16'd1;
      end
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_idx == CFG_LED_COUNT) led_count_r <= cfg_data[4:0];
        else                          tick_ms_r   <= cfg_data;
      end
      // drain pending result into output register
      if (outfree) begin
        hold_v_r <= pend_v_r;
        hold_r   <= pend_r;
        if (pend_v_r && !walk_emit) pend_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_cmd.mode)
              MODE_TICK: begin
                state_r <= ST_WALK;
                idx_r   <= 5'd0;
              end
              MODE_ASSIGN: begin
                pend_v_r <= 1'b1;
                pend_r   <= '{kind: KIND_STATUS, led_index: q_cmd.led_id, pin_level: 1'b0,
                              status: !({1'b0, q_cmd.led_id} < live && sval_r[q_cmd.seq_id]),
                              last: 1'b1};
                if ({1'b0, q_cmd.led_id} < live && sval_r[q_cmd.seq_id]) begin
                  pat_r[q_cmd.led_id] <= q_cmd.seq_id;
                  asg_r[q_cmd.led_id] <= 1'b1;
                  pos_r[q_cmd.led_id] <= 4'd0;
                  ela_r[q_cmd.led_id] <= 32'd0;
                  st_r[q_cmd.led_id]  <= 1'b0;
                end
              end
              MODE_ENABLE:
                if ({1'b0, q_cmd.led_id} < live) en_r[q_cmd.led_id] <= 1'b1;
              MODE_DISABLE:
                if ({1'b0, q_cmd.led_id} < live) en_r[q_cmd.led_id] <= 1'b0;
              MODE_OFFSET:
                if ({1'b0, q_cmd.led_id} < live) pos_r[q_cmd.led_id] <= q_cmd.step_index;
              MODE_STEP_WR:
                bits_r[q_cmd.seq_id][q_cmd.step_index] <= q_cmd.level;
              MODE_HEADER_WR: begin
                len_r[q_cmd.seq_id]  <= clen;
                sval_r[q_cmd.seq_id] <= 1'b1;
                dsid_r  <= q_cmd.seq_id;
                dlen_r  <= clen;
                dq_r    <= q_cmd.seq_period;
                drem_r  <= 16'd0;
                dcnt_r  <= 5'd0;
                state_r <= ST_DIV;
              end
              MODE_FORCE_ON:
                if (led_count_r != 5'd0 && en_r[q_cmd.led_id]) begin
                  pend_v_r <= 1'b1;
                  pend_r   <= '{kind: KIND_PIN, led_index: q_cmd.led_id, pin_level: 1'b1,
                                status: 1'b0, last: 1'b1};
                end
              MODE_FORCE_OFF:
                if (led_count_r != 5'd0) begin
                  pend_v_r <= 1'b1;
                  pend_r   <= '{kind: KIND_PIN, led_index: q_cmd.led_id, pin_level: 1'b0,
                                status: 1'b0, last: 1'b1};
                end
              default: ;
            endcase
          end
        end
        // one LED per cycle while the output does not stall a full pending slot; a result waits in the pending slot
        ST_WALK: begin
          if (pend_v_r && !outfree) begin
            // stall
          end else if (wk_done) begin
            // walk done: the final result already got last via lookahead
            state_r <= ST_IDLE;
          end else begin
            if (wact) begin
              ela_r[wi] <= enew;
              pos_r[wi] <= pnew;
              if (en_r[wi]) begin
                st_r[wi] <= 1'b1;
                pend_v_r <= 1'b1;
                pend_r   <= '{kind: KIND_PIN, led_index: wi,
                              pin_level: bits_r[wp][pnew], status: 1'b0,
                              last: !has_more(idx_r + 5'd1)};
              end
            end
            idx_r <= idx_r + 5'd1;
          end
        end
        // restoring division, one quotient bit a cycle
        ST_DIV: begin
          if (!dtrial[16]) drem_r <= dtrial[15:0];
          else             drem_r <= {drem_r[14:0], dq_r[15]};
          dq_r   <= {dq_r[14:0], !dtrial[16]};
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd15) begin
            thr_r[dsid_r] <= {dq_r[14:0], !dtrial[16]};
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/led_pattern_sequencer.sv]
// An accepted word passes the command queue, then the pending slot and output register.
// One word a cycle is taken while no result is pending; a word with a result holds the
// next until it drains, a header write holds it until the serial divider is done, and a
// stalled output stalls the LED walk.
// Reset: synchronous active-low; reloads patterns 0 and 1 and invalidates the rest.
// ----------------------------------------------------------------------------
// led_pattern_sequencer
// Top level: command queue in front, pattern engine behind.
// ----------------------------------------------------------------------------
module led_pattern_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[3:0], led_id[7:4], seq_id[10:8], step_index[14:11], level[15],
  // seq_length[20:16], seq_period[36:21], zero fill
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // led_index[3:0], pin_level[4], status[5], zero fill
  output logic [7:0]  out_tdata,
  output logic        out_tuser,   // kind
  output logic        out_tlast
);
  import lps_pkg::*;

  cmd_t cmd, q_cmd;
  res_t res;
  logic q_valid, q_pop, busy;

  assign cmd = '{mode: in_tdata[3:0], led_id: in_tdata[7:4], seq_id: in_tdata[10:8],
                 step_index: in_tdata[14:11], level: in_tdata[15],
                 seq_length: in_tdata[20:16], seq_period: in_tdata[36:21]};

  lps_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd(cmd),
    .q_valid, .q_pop, .q_cmd
  );

  lps_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .q_valid, .q_pop, .q_cmd,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res), .busy
  );

  assign out_tdata = {2'b00, res.status, res.pin_level, res.led_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

`ifndef NO_ASSERTIONS
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast) else $error("status word without last");
  a_status_pin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[4]) else $error("status word with pin level");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> busy) else $error("output valid while idle");
`endif

endmodule
